[src/sie_pkg.sv]
// Shared types and constants for the sorted insert engine.
// Used by sie_cell, sorted_insert_engine_top and sie_checker.
package sie_pkg;

  localparam int DATA_W       = 32;
  localparam int KIND_W       = 2;
  localparam int IDX_W        = 6;
  localparam int POS_W        = 6;
  localparam int TOTAL_W      = 7;
  localparam int DEF_CAPACITY = 64;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_READ   = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_t;

  // Broadcast from the top level to every cell
  typedef struct packed {
    logic                     ins_en;
    logic                     clr_en;
    logic                     any_gt;
    logic signed [DATA_W-1:0] value;
    logic [IDX_W-1:0]         rd_index;
  } cell_ctrl_t;

  // Handed from one cell to its right neighbor
  typedef struct packed {
    logic                     valid;
    logic                     mark;
    logic signed [DATA_W-1:0] data;
  } cell_link_t;

  // Per-cell status gathered by the top level
  typedef struct packed {
    logic                     gt;
    logic                     onehot;
    logic                     hit;
    logic signed [DATA_W-1:0] rd_data;
  } cell_stat_t;

endpackage

[src/sie_cell.sv]
// One compare-and-shift cell: holds one entry and its valid bit.
// Depends on sie_pkg.
module sie_cell #(
  parameter int CELL_INDEX = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sie_pkg::cell_ctrl_t ctrl_i,
  input  sie_pkg::cell_link_t left_i,
  output sie_pkg::cell_link_t right_o,
  output sie_pkg::cell_stat_t stat_o
);
  import sie_pkg::*;

  logic                     valid_r;
  logic                     valid_nxt;
  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;
  logic                     lt;
  logic                     mark;

  // mark: this cell sits at or after the insert slot
  assign lt   = $signed(data_r) < $signed(ctrl_i.value);
  assign mark = !valid_r || (!lt && ctrl_i.any_gt);

  assign right_o.valid = valid_r;
  assign right_o.mark  = mark;
  assign right_o.data  = data_r;

  assign stat_o.gt      = valid_r && ($signed(data_r) > $signed(ctrl_i.value));
  assign stat_o.onehot  = mark && !left_i.mark;
  assign stat_o.hit     = valid_r && (int'(ctrl_i.rd_index) == CELL_INDEX);
  assign stat_o.rd_data = stat_o.hit ? data_r : '0;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (ctrl_i.clr_en) begin
      valid_nxt = 1'b0;
    end else if (ctrl_i.ins_en) begin
      valid_nxt = left_i.valid;
      if (left_i.mark) begin
        data_nxt = left_i.data;
      end else if (mark) begin
        data_nxt = ctrl_i.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

[src/sorted_insert_engine_top.sv]
// Sorted insert engine: ascending store of signed entries kept in a row of cells.
// Results are registered and valid in the cycle after input transfer; throughput is
// one item per cycle while unstalled, set by the single compare-and-shift step.
// Input stalls only while a finished result waits on a stalled output.
// Synchronous active-low reset empties the store and drops any pending result.
// Depends on sie_pkg and sie_cell.
module sorted_insert_engine_top #(
  parameter int CAPACITY = sie_pkg::DEF_CAPACITY
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [sie_pkg::KIND_W-1:0]        in_kind,
  input  logic signed [sie_pkg::DATA_W-1:0] in_value,
  input  logic [sie_pkg::IDX_W-1:0]         in_index,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [sie_pkg::POS_W-1:0]         out_position,
  output logic signed [sie_pkg::DATA_W-1:0] out_read_data,
  output logic [sie_pkg::TOTAL_W-1:0]       out_entry_total,
  output logic                              out_refused
);
  import sie_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = $clog2(CAPACITY);

  cell_link_t link [CAPACITY+1];
  cell_stat_t stat [CAPACITY];
  cell_ctrl_t ctrl;

  logic                     accept;
  logic                     full;
  logic                     is_ins;
  logic                     is_rd;
  logic                     is_clr;
  logic                     any_gt;
  logic                     rd_hit;
  logic signed [DATA_W-1:0] rd_data;
  logic [PW-1:0]            pos_enc;

  logic [CW-1:0]            count_r;
  logic [CW-1:0]            count_nxt;
  logic                     out_valid_r;
  logic                     out_valid_nxt;
  logic [POS_W-1:0]         position_r;
  logic [POS_W-1:0]         position_nxt;
  logic signed [DATA_W-1:0] read_data_r;
  logic signed [DATA_W-1:0] read_data_nxt;
  logic [TOTAL_W-1:0]       total_r;
  logic [TOTAL_W-1:0]       total_nxt;
  logic                     refused_r;
  logic                     refused_nxt;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign is_ins   = (in_kind == KIND_INSERT);
  assign is_rd    = (in_kind == KIND_READ);
  assign is_clr   = (in_kind == KIND_CLEAR);
  assign full     = link[CAPACITY].valid;

  // Head of the row: always valid, never marked
  assign link[0].valid = 1'b1;
  assign link[0].mark  = 1'b0;
  assign link[0].data  = '0;

  always_comb begin
    any_gt = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      any_gt = any_gt | stat[i].gt;
    end
  end

  assign ctrl.ins_en   = accept && is_ins && !full;
  assign ctrl.clr_en   = accept && is_clr;
  assign ctrl.any_gt   = any_gt;
  assign ctrl.value    = in_value;
  assign ctrl.rd_index = in_index;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    sie_cell #(
      .CELL_INDEX(g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl_i  (ctrl),
      .left_i  (link[g]),
      .right_o (link[g+1]),
      .stat_o  (stat[g])
    );
  end

  always_comb begin
    rd_hit  = 1'b0;
    rd_data = '0;
    pos_enc = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_hit  = rd_hit | stat[i].hit;
      rd_data = rd_data | stat[i].rd_data;
      if (stat[i].onehot) begin
        pos_enc = pos_enc | PW'(i);
      end
    end
  end

  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    position_nxt  = position_r;
    read_data_nxt = read_data_r;
    total_nxt     = total_r;
    refused_nxt   = refused_r;
    if (ctrl.clr_en) begin
      count_nxt = '0;
    end else if (ctrl.ins_en) begin
      count_nxt = count_r + CW'(1);
    end
    if (accept) begin
      out_valid_nxt = 1'b1;
      position_nxt  = ctrl.ins_en ? POS_W'(pos_enc) : '0;
      read_data_nxt = (is_rd && rd_hit) ? rd_data : '0;
      total_nxt     = TOTAL_W'(count_nxt);
      refused_nxt   = (is_ins && full) || (is_rd && !rd_hit);
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    position_r  <= position_nxt;
    read_data_r <= read_data_nxt;
    total_r     <= total_nxt;
    refused_r   <= refused_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_position    = position_r;
  assign out_read_data   = read_data_r;
  assign out_entry_total = total_r;
  assign out_refused     = refused_r;

endmodule

[src/sie_checker.sv]
// Port-level checks for the sorted insert engine, bound to the top level.
// Depends on sie_pkg.
module sie_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic [sie_pkg::KIND_W-1:0]        in_kind,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [sie_pkg::POS_W-1:0]         out_position,
  input logic signed [sie_pkg::DATA_W-1:0] out_read_data,
  input logic [sie_pkg::TOTAL_W-1:0]       out_entry_total,
  input logic                              out_refused
);
  import sie_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_position) &&
      $stable(out_read_data) && $stable(out_entry_total) && $stable(out_refused))
    else $error("stalled result changed");

  // Every input transfer yields a result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("transfer without result");

  // Stall input only behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no pending result");

  // A refused item reports no position and no data
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_refused |-> out_position == '0 && out_read_data == '0)
    else $error("refused result carries data");

  // Clear empties the store
  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_kind == KIND_CLEAR |=> out_entry_total == '0)
    else $error("clear left entries");

endmodule

bind sorted_insert_engine_top sie_checker u_sie_checker (.*);
